@@ rtl/cpg_pkg.sv @@
package cpg_pkg;

	// one reference character
	typedef struct packed {
		logic [7:0] base;
		logic       last_base;
	} in_item_t;

	// one group report
	typedef struct packed {
		logic [30:0] first_coord;
		logic [30:0] last_coord;
		logic [9:0]  site_count;
		logic        last_result;
	} out_item_t;

	// up to two reports produced by one request, compacted into first/second
	typedef struct packed {
		logic [1:0] num;
		out_item_t  first;
		out_item_t  second;
	} res_push_t;

	typedef enum logic [1:0] {
		CLS_NONE = 2'd0,
		CLS_C    = 2'd1,
		CLS_G    = 2'd2
	} base_cls_t;

	localparam logic [1:0] CFG_REF_OFFSET = 2'd0;
	localparam logic [1:0] CFG_MIN_GAP    = 2'd1;
	localparam logic [1:0] CFG_MAX_SPAN   = 2'd2;

	localparam logic [30:0] REF_OFFSET_RST = 31'd0;
	localparam logic [7:0]  MIN_GAP_RST    = 8'd10;
	localparam logic [9:0]  MAX_SPAN_RST   = 10'd200;

	localparam logic [9:0] COUNT_MAX = 10'd1023;

	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_Z = 8'h7a;
	localparam logic [7:0] CH_CASE  = 8'h20;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_K     = 8'h4b;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_Y     = 8'h59;

	// result queue
	localparam int RQ_DEPTH = 8;
	localparam int RQ_AW    = 3;
	// a request in flight plus a new one may push four entries
	localparam logic [RQ_AW:0] RQ_STALL_LEVEL = (RQ_AW+1)'(RQ_DEPTH - 4);

	function automatic base_cls_t classify(input logic [7:0] code);
		logic [7:0] ch;
		base_cls_t  cls;
		ch = code;
		if (ch >= CH_LOW_A && ch <= CH_LOW_Z) begin
			ch = ch - CH_CASE;
		end
		case (ch) inside
			CH_C, CH_S, CH_Y, CH_B: cls = CLS_C;
			CH_G, CH_K:             cls = CLS_G;
			default:                cls = CLS_NONE;
		endcase
		return cls;
	endfunction

endpackage

@@ rtl/cpg_group_core.sv @@
module cpg_group_core #(
	parameter int MAX_SEQ_LEN = 1048576
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  cpg_pkg::in_item_t  item,
	input  logic [30:0]        ref_offset,
	input  logic [7:0]         min_gap,
	input  logic [9:0]         max_span,
	output cpg_pkg::res_push_t push
);
	import cpg_pkg::*;

	localparam int SiteW = $clog2(MAX_SEQ_LEN);
	localparam int PosW  = $clog2(MAX_SEQ_LEN + 1);

	logic [PosW-1:0]  pos_q;
	logic             prev_c_q;
	logic             open_q;
	logic [SiteW-1:0] first_q;
	logic [SiteW-1:0] last_q;
	logic [9:0]       count_q;

	logic             in_range;
	base_cls_t        cls;
	logic             site_hit;
	logic [SiteW-1:0] site;
	logic             far;
	logic             close_a;
	logic             close_b;
	logic             keep_a;
	logic             keep_b;
	logic             open_n;
	logic [SiteW-1:0] first_n;
	logic [SiteW-1:0] last_n;
	logic [9:0]       count_n;
	logic [PosW-1:0]  pos_n;
	out_item_t        res_a;
	out_item_t        res_b;

	function automatic logic group_keeps(input logic [SiteW-1:0] f, input logic [SiteW-1:0] l,
			input logic [7:0] gap, input logic [9:0] span_max);
		logic [8:0] twice_gap;
		twice_gap = {gap, 1'b0};
		return (f > SiteW'(twice_gap)) && ((l - f) <= SiteW'(span_max));
	endfunction

	function automatic out_item_t make_result(input logic [SiteW-1:0] f,
			input logic [SiteW-1:0] l, input logic [9:0] cnt, input logic [30:0] offs,
			input logic fin);
		out_item_t r;
		r.first_coord = 31'(f) + offs;
		r.last_coord  = 31'(l) + offs;
		r.site_count  = cnt;
		r.last_result = fin;
		return r;
	endfunction

	always_comb begin
		in_range = pos_q < PosW'(MAX_SEQ_LEN);
		cls      = in_range ? classify(item.base) : CLS_NONE;
		site_hit = item_valid && (cls == CLS_G) && prev_c_q && (pos_q != '0);
		site     = SiteW'(pos_q - PosW'(1));
		far      = open_q && ((site - last_q) > SiteW'(min_gap));
		close_a  = site_hit && far;

		// group state after this base's site, if any
		if (site_hit && open_q && !far) begin
			first_n = first_q;
			last_n  = site;
			count_n = (count_q < COUNT_MAX) ? count_q + 10'd1 : count_q;
		end else if (site_hit) begin
			first_n = site;
			last_n  = site;
			count_n = 10'd1;
		end else begin
			first_n = first_q;
			last_n  = last_q;
			count_n = count_q;
		end
		open_n  = open_q || site_hit;
		close_b = item_valid && item.last_base && open_n;

		keep_a = close_a && group_keeps(first_q, last_q, min_gap, max_span);
		keep_b = close_b && group_keeps(first_n, last_n, min_gap, max_span);

		res_a = make_result(first_q, last_q, count_q, ref_offset, !keep_b);
		res_b = make_result(first_n, last_n, count_n, ref_offset, 1'b1);

		push.num    = {1'b0, keep_a} + {1'b0, keep_b};
		push.first  = keep_a ? res_a : res_b;
		push.second = res_b;

		pos_n = in_range ? pos_q + PosW'(1) : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			prev_c_q <= 1'b0;
			open_q   <= 1'b0;
			first_q  <= '0;
			last_q   <= '0;
			count_q  <= '0;
		end else if (item_valid) begin
			first_q <= first_n;
			last_q  <= last_n;
			count_q <= count_n;
			if (item.last_base) begin
				pos_q    <= '0;
				prev_c_q <= 1'b0;
				open_q   <= 1'b0;
			end else begin
				pos_q    <= pos_n;
				prev_c_q <= (cls == CLS_C);
				open_q   <= open_n;
			end
		end
	end

endmodule

@@ rtl/cpg_result_fifo.sv @@
module cpg_result_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cpg_pkg::res_push_t   push,
	output logic                 out_valid,
	input  logic                 out_stall,
	output cpg_pkg::out_item_t   out_data,
	output logic [cpg_pkg::RQ_AW:0] level
);
	import cpg_pkg::*;

	out_item_t        mem [RQ_DEPTH];
	logic [RQ_AW-1:0] wr_ptr_q;
	logic [RQ_AW-1:0] rd_ptr_q;
	logic [RQ_AW:0]   level_q;
	logic             pop;

	assign out_valid = level_q != '0;
	assign out_data  = mem[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem[wr_ptr_q] <= push.first;
		end
		if (push.num == 2'd2) begin
			mem[wr_ptr_q + RQ_AW'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RQ_AW'(push.num);
			rd_ptr_q <= rd_ptr_q + RQ_AW'(pop);
			level_q  <= level_q + (RQ_AW+1)'(push.num) - (RQ_AW+1)'(pop);
		end
	end

endmodule

@@ rtl/cpg_site_grouper_unit.sv @@
// channel  | valid      | stall      | payload
// ---------+------------+------------+------------------------------
// input    | in_valid   | in_stall   | in_data  (base, last_base)
// output   | out_valid  | out_stall  | out_data (group report)
// config   | cfg_write  | -          | cfg_index, cfg_data
//
// one base per cycle while in_stall is low: a request is registered, then classified
// and grouped in the next cycle, and its zero to two group reports land in an
// eight-entry result queue that drains one a cycle while out_stall is low
// a base closing two groups puts two reports in the queue
// in_stall rises only when the queue holds more than four reports
// reset returns the position, grouping state and registers to their defaults
module cpg_site_grouper_unit #(
	parameter int MAX_SEQ_LEN = 1048576
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  cpg_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output cpg_pkg::out_item_t out_data,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data
);
	import cpg_pkg::*;

	logic [30:0]    ref_offset_q;
	logic [7:0]     min_gap_q;
	logic [9:0]     max_span_q;
	logic           valid_s1;
	in_item_t       item_s1;
	res_push_t      push;
	logic [RQ_AW:0] level;

	assign in_stall = level > RQ_STALL_LEVEL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_offset_q <= REF_OFFSET_RST;
			min_gap_q    <= MIN_GAP_RST;
			max_span_q   <= MAX_SPAN_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_REF_OFFSET: ref_offset_q <= cfg_data;
				CFG_MIN_GAP:    min_gap_q    <= cfg_data[7:0];
				CFG_MAX_SPAN:   max_span_q   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && !in_stall;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	cpg_group_core #(
		.MAX_SEQ_LEN(MAX_SEQ_LEN)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(valid_s1),
		.item      (item_s1),
		.ref_offset(ref_offset_q),
		.min_gap   (min_gap_q),
		.max_span  (max_span_q),
		.push      (push)
	);

	cpg_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.level    (level)
	);

endmodule
